/* rtl/stick_circular_deadzone_top_defines.svh */
// Assertion macros for the stick dead-zone block
`ifndef STICK_CIRCULAR_DEADZONE_TOP_DEFINES_SVH
`define STICK_CIRCULAR_DEADZONE_TOP_DEFINES_SVH
`ifndef SYNTH
`define SCD_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error("assertion failed");
`define SCD_ASSERT_RST(label, clk, prop) \
  label: assert property (@(posedge clk) (prop)) else $error("assertion failed");
`else
`define SCD_ASSERT(label, clk, rst, prop)
`define SCD_ASSERT_RST(label, clk, prop)
`endif
`endif

/* rtl/scd_pkg.sv */
// ----------------------------------------------------------------------------
// scd_pkg
// Shared types and constants for the stick circular dead-zone block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package scd_pkg;
  localparam logic [14:0] FullScale = 15'd32767;
  localparam logic [0:0]  RegRadius = 1'd0;

  // Front-to-back queue entry
  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic        [31:0] sum;
  } front_item_t;

  typedef struct packed {
    logic signed [15:0] scaled_x;
    logic signed [15:0] scaled_y;
    logic        [16:0] scale_q16;
  } result_t;
endpackage
`default_nettype wire

/* rtl/scd_stream_if.sv */
// ----------------------------------------------------------------------------
// scd_stream_if
// Valid/ready channel carrying a generic payload.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
interface scd_stream_if #(parameter type payload_t = logic [31:0]);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

/* rtl/stick_circular_deadzone_top.sv */
// Path: front, queue, back. Throughput: one sample per cycle while result.ready
// is high; set by the one-bit-per-stage root and divider pipes.
// Reset: synchronous active-high rst clears all valid bits, the queue and the radius (0).
// Back pressure stalls the back pipe; the queue absorbs the front's in-flight samples.
`timescale 1ns / 1ps
`default_nettype none
`include "stick_circular_deadzone_top_defines.svh"
// ----------------------------------------------------------------------------
// stick_circular_deadzone_top
// Circular dead-zone normalization of two-axis stick samples.
// ----------------------------------------------------------------------------
module stick_circular_deadzone_top (
  input  wire logic        clk,
  input  wire logic        rst,
  scd_stream_if.sink       stick,
  scd_stream_if.source     result,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  logic [14:0]          radius;
  logic                 f_valid, f_ready, q_valid, q_ready;
  scd_pkg::front_item_t f_item, q_item;
  scd_pkg::result_t     res;

  assign pready = 1'b1;

  // Register write and readback
  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= '0;
    end else if (psel && penable && pwrite && paddr[2] == scd_pkg::RegRadius
                 && paddr[1:0] == 2'b00) begin
      radius <= pwdata[14:0];
    end
  end
  assign prdata = (paddr[2] == scd_pkg::RegRadius) ? {17'b0, radius} : '0;

  scd_front u_front (
    .clk, .rst,
    .in_valid (stick.valid), .in_ready (stick.ready),
    .in_x (stick.data[31:16]), .in_y (stick.data[15:0]),
    .out_valid (f_valid), .out_ready (f_ready), .out_item (f_item)
  );

  scd_queue u_queue (
    .clk, .rst,
    .in_valid (f_valid), .in_ready (f_ready), .in_item (f_item),
    .out_valid (q_valid), .out_ready (q_ready), .out_item (q_item)
  );

  scd_back u_back (
    .clk, .rst, .radius,
    .in_valid (q_valid), .in_ready (q_ready), .in_item (q_item),
    .out_valid (result.valid), .out_ready (result.ready), .out_res (res)
  );
  assign result.data = res;

  `SCD_ASSERT(a_scale_max, clk, rst, result.valid |-> res.scale_q16 <= 17'd65536)
  `SCD_ASSERT(a_zero_scale, clk, rst,
    (result.valid && res.scale_q16 == 17'd0) |-> (res.scaled_x == 16'sd0 && res.scaled_y == 16'sd0))
  `SCD_ASSERT_RST(a_reset_radius, clk, $past(rst) |-> radius == 15'd0)
endmodule
`default_nettype wire

/* rtl/scd_front.sv */
// ----------------------------------------------------------------------------
// scd_front
// Accept samples and form the squared magnitude in two registered stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module scd_front (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [15:0] in_x,
  input  wire logic signed [15:0] in_y,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output scd_pkg::front_item_t    out_item
);
  logic               v1, v2;
  logic signed [15:0] x1, y1;
  logic        [30:0] sqx, sqy;
  logic               adv1, adv2;

  assign adv2     = !v2 || out_ready;
  assign adv1     = !v1 || adv2;
  assign in_ready = adv1;

  // Stage 1: squares of the absolute values
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv1) begin
      v1 <= in_valid;
    end
    if (adv1 && in_valid) begin
      x1  <= in_x;
      y1  <= in_y;
      sqx <= 31'(32'(in_x * in_x));
      sqy <= 31'(32'(in_y * in_y));
    end
  end

  // Stage 2: sum
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv2) begin
      v2 <= v1;
    end
    if (adv2 && v1) begin
      out_item.x   <= x1;
      out_item.y   <= y1;
      out_item.sum <= {1'b0, sqx} + {1'b0, sqy};
    end
  end
  assign out_valid = v2;
endmodule
`default_nettype wire

/* rtl/scd_queue.sv */
// ----------------------------------------------------------------------------
// scd_queue
// Short FIFO that decouples the front and back sections.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "stick_circular_deadzone_top_defines.svh"
module scd_queue (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire scd_pkg::front_item_t in_item,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output scd_pkg::front_item_t      out_item
);
  scd_pkg::front_item_t mem [4];
  logic [1:0] wr_ptr, rd_ptr;
  logic [2:0] count;
  logic       push, pop;

  assign in_ready  = count != 3'd4;
  assign out_valid = count != 3'd0;
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign out_item  = mem[rd_ptr];

  // Store entries
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_item;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 2'd1;
      if (pop)  rd_ptr <= rd_ptr + 2'd1;
      count <= count + {2'b0, push} - {2'b0, pop};
    end
  end

  `SCD_ASSERT(a_no_overflow, clk, rst, count <= 3'd4)
  `SCD_ASSERT(a_count_step, clk, rst, (push && !pop) |=> count == $past(count) + 3'd1)
  `SCD_ASSERT(a_ptr_gap, clk, rst, count[1:0] == 2'(wr_ptr - rd_ptr))
endmodule
`default_nettype wire

/* rtl/scd_back.sv */
// ----------------------------------------------------------------------------
// scd_back
// Pipelined square root, divider and axis scaling with output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module scd_back (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic [14:0]          radius,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire scd_pkg::front_item_t in_item,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output scd_pkg::result_t          out_res
);
  localparam int SqSteps  = 16;
  localparam int DivSteps = 17;
  localparam int Depth    = SqSteps + 1 + DivSteps + 2;

  logic [Depth-1:0] vld;
  logic             adv;

  // Whole pipeline stalls only when the output is held
  assign adv      = !vld[Depth-1] || out_ready;
  assign in_ready = adv;
  assign out_valid = vld[Depth-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[Depth-2:0], in_valid};
    end
  end

  // Square root: one result bit per stage
  logic signed [15:0] sq_x   [SqSteps+1];
  logic signed [15:0] sq_y   [SqSteps+1];
  logic        [31:0] sq_rem [SqSteps+1];
  logic        [15:0] sq_root[SqSteps+1];
  assign sq_x[0]    = in_item.x;
  assign sq_y[0]    = in_item.y;
  assign sq_rem[0]  = in_item.sum;
  assign sq_root[0] = '0;

  for (genvar i = 0; i < SqSteps; i++) begin : g_sqrt
    localparam int B = SqSteps - 1 - i;
    logic [33:0] trial;
    logic [31:0] rem_sh;
    always_comb begin
      trial  = ({18'b0, sq_root[i]} << (B + 1)) | (34'd1 << (2 * B));
      rem_sh = sq_rem[i];
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        sq_x[i+1] <= sq_x[i];
        sq_y[i+1] <= sq_y[i];
        if ({2'b0, rem_sh} >= trial) begin
          sq_rem[i+1]  <= 32'({2'b0, rem_sh} - trial);
          sq_root[i+1] <= sq_root[i] | (16'd1 << B);
        end else begin
          sq_rem[i+1]  <= rem_sh;
          sq_root[i+1] <= sq_root[i];
        end
      end
    end
  end

  // Clip, dead-zone test and divider setup
  logic signed [15:0] dv_x [DivSteps+1];
  logic signed [15:0] dv_y [DivSteps+1];
  logic        [32:0] dv_rem[DivSteps+1];
  logic        [15:0] dv_den[DivSteps+1];
  logic        [16:0] dv_q  [DivSteps+1];
  logic        [14:0] mag_c;
  assign mag_c = (sq_root[SqSteps] > {1'b0, scd_pkg::FullScale}) ? scd_pkg::FullScale
               : sq_root[SqSteps][14:0];
  // Inside the dead zone divide zero by one so the quotient stays zero
  always_ff @(posedge clk) begin
    if (adv) begin
      dv_x[0]   <= sq_x[SqSteps];
      dv_y[0]   <= sq_y[SqSteps];
      dv_rem[0] <= (mag_c > radius) ? {2'b0, 15'(mag_c - radius), 16'b0} : '0;
      dv_den[0] <= (mag_c > radius) ? {1'b0, 15'(scd_pkg::FullScale - radius)} : 16'd1;
      dv_q[0]   <= '0;
    end
  end

  // Restoring division: one quotient bit per stage
  for (genvar i = 0; i < DivSteps; i++) begin : g_div
    localparam int B = DivSteps - 1 - i;
    logic [48:0] dsh;
    assign dsh = {33'b0, dv_den[i]} << B;
    always_ff @(posedge clk) begin
      if (adv) begin
        dv_x[i+1]   <= dv_x[i];
        dv_y[i+1]   <= dv_y[i];
        dv_den[i+1] <= dv_den[i];
        if ({16'b0, dv_rem[i]} >= dsh) begin
          dv_rem[i+1] <= 33'({16'b0, dv_rem[i]} - dsh);
          dv_q[i+1]   <= dv_q[i] | (17'd1 << B);
        end else begin
          dv_rem[i+1] <= dv_rem[i];
          dv_q[i+1]   <= dv_q[i];
        end
      end
    end
  end

  // Multiply magnitudes by scale
  logic        [15:0] ax, ay;
  logic        [32:0] px, py;
  logic               nx, ny;
  logic        [16:0] sc;
  assign ax = dv_x[DivSteps][15] ? 16'(-dv_x[DivSteps]) : dv_x[DivSteps];
  assign ay = dv_y[DivSteps][15] ? 16'(-dv_y[DivSteps]) : dv_y[DivSteps];
  always_ff @(posedge clk) begin
    if (adv) begin
      px <= {17'b0, ax} * {16'b0, dv_q[DivSteps]};
      py <= {17'b0, ay} * {16'b0, dv_q[DivSteps]};
      nx <= dv_x[DivSteps][15];
      ny <= dv_y[DivSteps][15];
      sc <= dv_q[DivSteps];
    end
  end

  // Restore sign and register the result
  always_ff @(posedge clk) begin
    if (adv) begin
      out_res.scaled_x  <= nx ? 16'(-px[31:16]) : px[31:16];
      out_res.scaled_y  <= ny ? 16'(-py[31:16]) : py[31:16];
      out_res.scale_q16 <= sc;
    end
  end
endmodule
`default_nettype wire
